FILE: hdl/kfwrl_pkg.sv
// Shared types and constants of the keyed fixed-window rate limiter.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package kfwrl_pkg;

    // field and table geometry
    localparam int TIME_W     = 48;
    localparam int KEY_W      = 32;
    localparam int WIN_W      = 22;
    localparam int GLIM_W     = 20;
    localparam int IPLIM_W    = 17;
    localparam int ACLIM_W    = 14;
    localparam int CAP_W      = 9;
    localparam int TOT_W      = 32;
    localparam int RSN_W      = 3;
    localparam int NUM_RSN    = 5;
    localparam int TBL_DEPTH  = 256;
    localparam int IDX_W      = $clog2(TBL_DEPTH);
    localparam int SCAN_W     = $clog2(TBL_DEPTH + 1);
    localparam int LIVE_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // register reset values
    localparam logic [WIN_W-1:0]   WINDOW_RST   = WIN_W'(60000);
    localparam logic [GLIM_W-1:0]  GW_LIMIT_RST = GLIM_W'(1000);
    localparam logic [IPLIM_W-1:0] IP_LIMIT_RST = IPLIM_W'(20);
    localparam logic [ACLIM_W-1:0] AC_LIMIT_RST = ACLIM_W'(5);
    localparam logic [CAP_W-1:0]   MAX_KEYS_RST = CAP_W'(256);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW    = 3'd0,
        CFG_GATEWAY   = 3'd1,
        CFG_IP_LIMIT  = 3'd2,
        CFG_AC_LIMIT  = 3'd3,
        CFG_MAX_KEYS  = 3'd4
    } cfg_idx_t;

    // deny reasons
    typedef enum logic [RSN_W-1:0] {
        RSN_NONE    = 3'd0,
        RSN_GATEWAY = 3'd1,
        RSN_IP      = 3'd2,
        RSN_ACCT    = 3'd3,
        RSN_IP_CAP  = 3'd4,
        RSN_AC_CAP  = 3'd5
    } reason_t;

    typedef enum logic {
        TBL_IP   = 1'b0,
        TBL_ACCT = 1'b1
    } tbl_t;

    // table words
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  start;
        logic [IPLIM_W-1:0] count;
    } ip_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  start;
        logic [ACLIM_W-1:0] count;
    } ac_word_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    sweep_begin;
        logic    find_begin;
        logic    scan_run;
        tbl_t    tsel;
        logic    chg_s1;
        logic    chg_s2;
        logic    chg_keyed;
        logic    commit_global;
        logic    commit_key;
        logic    remove;
        logic    result;
        reason_t reason;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_due;
        logic scan_done;
        logic match_found;
        logic free_found;
        logic table_full;
        logic chg_deny;
    } sts_t;

endpackage

`default_nettype wire

FILE: hdl/kfwrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kfwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/kfwrl_ctrl.sv
// Sequencer of the rate limiter: sweep, global charge, keyed lookups, result or removal.
// Depends on kfwrl_pkg; drives the datapath through cmd_t, reads sts_t.
`default_nettype none

module kfwrl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              action,
    input  wire kfwrl_pkg::sts_t   sts,
    output kfwrl_pkg::cmd_t        cmd,
    output logic                   busy
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SWCHK  = 14'b00000000000010,
        S_SWEEP  = 14'b00000000000100,
        S_G1     = 14'b00000000001000,
        S_G2     = 14'b00000000010000,
        S_GC     = 14'b00000000100000,
        S_FSTART = 14'b00000001000000,
        S_FIND   = 14'b00000010000000,
        S_DECIDE = 14'b00000100000000,
        S_K1     = 14'b00001000000000,
        S_K2     = 14'b00010000000000,
        S_KC     = 14'b00100000000000,
        S_RESULT = 14'b01000000000000,
        S_REMOVE = 14'b10000000000000
    } state_t;

    state_t             state_reg, state_next;
    kfwrl_pkg::tbl_t    tsel_reg, tsel_next;
    kfwrl_pkg::reason_t reason_reg, reason_next;
    logic               capsw_reg, capsw_next;
    logic               succ_reg, succ_next;

    // state and context registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tsel_reg   <= kfwrl_pkg::TBL_IP;
            reason_reg <= kfwrl_pkg::RSN_NONE;
            capsw_reg  <= 1'b0;
            succ_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tsel_reg   <= tsel_next;
            reason_reg <= reason_next;
            capsw_reg  <= capsw_next;
            succ_reg   <= succ_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        tsel_next   = tsel_reg;
        reason_next = reason_reg;
        capsw_next  = capsw_reg;
        succ_next   = succ_reg;
        cmd         = '0;
        cmd.tsel    = tsel_reg;
        cmd.reason  = reason_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    succ_next   = action;
                    capsw_next  = 1'b0;
                    reason_next = kfwrl_pkg::RSN_NONE;
                    if (action)
                    begin
                        tsel_next  = kfwrl_pkg::TBL_ACCT;
                        state_next = S_FSTART;
                    end
                    else
                    begin
                        tsel_next  = kfwrl_pkg::TBL_IP;
                        state_next = S_SWCHK;
                    end
                end
            end
            S_SWCHK:
            begin
                if (sts.sweep_due)
                begin
                    cmd.sweep_begin = 1'b1;
                    state_next      = S_SWEEP;
                end
                else
                begin
                    state_next = capsw_reg ? S_FSTART : S_G1;
                end
            end
            S_SWEEP:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = capsw_reg ? S_FSTART : S_G1;
                end
            end
            S_G1:
            begin
                cmd.chg_s1 = 1'b1;
                state_next = S_G2;
            end
            S_G2:
            begin
                cmd.chg_s2 = 1'b1;
                state_next = S_GC;
            end
            S_GC:
            begin
                cmd.commit_global = 1'b1;
                if (sts.chg_deny)
                begin
                    reason_next = kfwrl_pkg::RSN_GATEWAY;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_FSTART;
                end
            end
            S_FSTART:
            begin
                cmd.find_begin = 1'b1;
                state_next     = S_FIND;
            end
            S_FIND:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = succ_reg ? S_REMOVE : S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.match_found)
                begin
                    state_next = S_K1;
                end
                else if (sts.table_full && !capsw_reg)
                begin
                    // full table: one more sweep attempt, then look again
                    capsw_next = 1'b1;
                    state_next = S_SWCHK;
                end
                else if (sts.table_full || !sts.free_found)
                begin
                    reason_next = (tsel_reg == kfwrl_pkg::TBL_IP) ?
                                  kfwrl_pkg::RSN_IP_CAP : kfwrl_pkg::RSN_AC_CAP;
                    state_next  = S_RESULT;
                end
                else
                begin
                    state_next = S_K1;
                end
            end
            S_K1:
            begin
                cmd.chg_s1    = 1'b1;
                cmd.chg_keyed = 1'b1;
                state_next    = S_K2;
            end
            S_K2:
            begin
                cmd.chg_s2    = 1'b1;
                cmd.chg_keyed = 1'b1;
                state_next    = S_KC;
            end
            S_KC:
            begin
                cmd.commit_key = 1'b1;
                if (sts.chg_deny)
                begin
                    reason_next = (tsel_reg == kfwrl_pkg::TBL_IP) ?
                                  kfwrl_pkg::RSN_IP : kfwrl_pkg::RSN_ACCT;
                    state_next  = S_RESULT;
                end
                else if (tsel_reg == kfwrl_pkg::TBL_IP)
                begin
                    tsel_next  = kfwrl_pkg::TBL_ACCT;
                    capsw_next = 1'b0;
                    state_next = S_FSTART;
                end
                else
                begin
                    reason_next = kfwrl_pkg::RSN_NONE;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                cmd.result = 1'b1;
                state_next = S_IDLE;
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/kfwrl_dp.sv
// Datapath of the rate limiter: config, tables, scan engine, charge unit, totals.
// Depends on kfwrl_pkg and kfwrl_ram; driven by kfwrl_ctrl through cmd_t.
`default_nettype none

module kfwrl_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [kfwrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kfwrl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [kfwrl_pkg::TIME_W-1:0]        now_ms,
    input  wire logic [kfwrl_pkg::KEY_W-1:0]         ip_key,
    input  wire logic [kfwrl_pkg::KEY_W-1:0]         account_key,
    input  wire kfwrl_pkg::cmd_t                     cmd,
    output kfwrl_pkg::sts_t                          sts,
    output logic                                     done,
    output logic                                     allowed,
    output logic [kfwrl_pkg::RSN_W-1:0]              deny_reason,
    output logic [kfwrl_pkg::WIN_W-1:0]              retry_after_ms,
    output logic [kfwrl_pkg::TOT_W-1:0]              allowed_total,
    output logic [kfwrl_pkg::TOT_W-1:0]              denied_total,
    output logic [kfwrl_pkg::TOT_W-1:0]              reason_denied_total,
    output logic [kfwrl_pkg::LIVE_W-1:0]             ip_entries_in_use,
    output logic [kfwrl_pkg::LIVE_W-1:0]             account_entries_in_use
);

    localparam int TW    = kfwrl_pkg::TIME_W;
    localparam int WW    = kfwrl_pkg::WIN_W;
    localparam int GW    = kfwrl_pkg::GLIM_W;
    localparam int IW    = kfwrl_pkg::IDX_W;
    localparam int SW    = kfwrl_pkg::SCAN_W;
    localparam int LW    = kfwrl_pkg::LIVE_W;
    localparam int CW    = kfwrl_pkg::CAP_W;
    localparam int KCW   = kfwrl_pkg::IPLIM_W;
    localparam int OW    = kfwrl_pkg::TOT_W;
    localparam int DEPTH = kfwrl_pkg::TBL_DEPTH;

    // configuration
    logic [WW-1:0]                 window_reg;
    logic [GW-1:0]                 gw_limit_reg;
    logic [kfwrl_pkg::IPLIM_W-1:0] ip_limit_reg;
    logic [kfwrl_pkg::ACLIM_W-1:0] ac_limit_reg;
    logic [CW-1:0]                 max_keys_reg;

    // latched item
    logic [TW-1:0]                 now_reg;
    logic [kfwrl_pkg::KEY_W-1:0]   ip_key_reg;
    logic [kfwrl_pkg::KEY_W-1:0]   ac_key_reg;

    // global window and sweep time
    logic [TW-1:0]                 gstart_reg;
    logic [GW-1:0]                 gcount_reg;
    logic [TW-1:0]                 last_sweep_reg;

    // table state
    logic [DEPTH-1:0]              ip_valid_reg;
    logic [DEPTH-1:0]              ac_valid_reg;
    logic [LW-1:0]                 ip_live_reg;
    logic [LW-1:0]                 ac_live_reg;

    // scan engine
    logic [SW-1:0]                 idx_reg;
    logic [IW-1:0]                 eidx_reg;
    logic                          evalid_reg;
    logic                          sweep_mode_reg;
    logic                          match_reg;
    logic                          free_reg;
    logic [IW-1:0]                 match_idx_reg;
    logic [IW-1:0]                 free_idx_reg;
    logic [TW-1:0]                 cur_start_reg;
    logic [KCW-1:0]                cur_count_reg;

    // charge unit
    logic [TW-1:0]                 s1_start_reg;
    logic [GW-1:0]                 s1_count_reg;
    logic                          deny_reg;
    logic [WW-1:0]                 retry_reg;
    logic [GW-1:0]                 cnt_out_reg;

    // totals
    logic [OW-1:0]                 allowed_tot_reg;
    logic [OW-1:0]                 denied_tot_reg;
    logic [OW-1:0]                 per_reason_reg [kfwrl_pkg::NUM_RSN];

    // table RAMs
    kfwrl_pkg::ip_word_t           ip_rdata, ip_wdata;
    kfwrl_pkg::ac_word_t           ac_rdata, ac_wdata;
    logic                          ip_we, ac_we;
    logic [IW-1:0]                 slot;

    function automatic logic win_over(input logic [TW-1:0] s, input logic [TW-1:0] n,
                                      input logic [WW-1:0] w);
        logic [TW-1:0] d;
        begin
            d = n - s;
            return (s == '0) || (n < s) || (d >= TW'(w));
        end
    endfunction

    function automatic logic [OW-1:0] sat_inc(input logic [OW-1:0] x);
        begin
            return (x == '1) ? x : x + OW'(1);
        end
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= kfwrl_pkg::WINDOW_RST;
            gw_limit_reg <= kfwrl_pkg::GW_LIMIT_RST;
            ip_limit_reg <= kfwrl_pkg::IP_LIMIT_RST;
            ac_limit_reg <= kfwrl_pkg::AC_LIMIT_RST;
            max_keys_reg <= kfwrl_pkg::MAX_KEYS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kfwrl_pkg::CFG_WINDOW:   window_reg   <= cfg_data[WW-1:0];
                kfwrl_pkg::CFG_GATEWAY:  gw_limit_reg <= cfg_data[GW-1:0];
                kfwrl_pkg::CFG_IP_LIMIT: ip_limit_reg <= cfg_data[kfwrl_pkg::IPLIM_W-1:0];
                kfwrl_pkg::CFG_AC_LIMIT: ac_limit_reg <= cfg_data[kfwrl_pkg::ACLIM_W-1:0];
                kfwrl_pkg::CFG_MAX_KEYS: max_keys_reg <= cfg_data[CW-1:0];
                default:                 ;
            endcase
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= now_ms;
            ip_key_reg <= ip_key;
            ac_key_reg <= account_key;
        end
    end

    kfwrl_ram #(.WIDTH($bits(kfwrl_pkg::ip_word_t)), .DEPTH(DEPTH)) u_ip_ram (
        .clk   (clk),
        .we    (ip_we),
        .waddr (slot),
        .wdata (ip_wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (ip_rdata)
    );

    kfwrl_ram #(.WIDTH($bits(kfwrl_pkg::ac_word_t)), .DEPTH(DEPTH)) u_ac_ram (
        .clk   (clk),
        .we    (ac_we),
        .waddr (slot),
        .wdata (ac_wdata),
        .raddr (idx_reg[IW-1:0]),
        .rdata (ac_rdata)
    );

    // entry under evaluation
    logic          is_ip;
    logic          ip_clr, ac_clr;
    logic          t_valid;
    logic [kfwrl_pkg::KEY_W-1:0] t_key, find_key;
    logic [TW-1:0] t_start;
    logic [KCW-1:0] t_count;
    logic          find_ev;

    assign is_ip    = (cmd.tsel == kfwrl_pkg::TBL_IP);
    assign ip_clr   = evalid_reg && sweep_mode_reg && ip_valid_reg[eidx_reg] &&
                      win_over(ip_rdata.start, now_reg, window_reg);
    assign ac_clr   = evalid_reg && sweep_mode_reg && ac_valid_reg[eidx_reg] &&
                      win_over(ac_rdata.start, now_reg, window_reg);
    assign t_valid  = is_ip ? ip_valid_reg[eidx_reg] : ac_valid_reg[eidx_reg];
    assign t_key    = is_ip ? ip_rdata.key : ac_rdata.key;
    assign t_start  = is_ip ? ip_rdata.start : ac_rdata.start;
    assign t_count  = is_ip ? ip_rdata.count : KCW'(ac_rdata.count);
    assign find_key = is_ip ? ip_key_reg : ac_key_reg;
    assign find_ev  = evalid_reg && !sweep_mode_reg;

    // scan index and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            evalid_reg     <= 1'b0;
            sweep_mode_reg <= 1'b0;
        end
        else if (cmd.sweep_begin || cmd.find_begin)
        begin
            idx_reg        <= '0;
            evalid_reg     <= 1'b0;
            sweep_mode_reg <= cmd.sweep_begin;
        end
        else if (cmd.scan_run && (idx_reg < SW'(DEPTH)))
        begin
            idx_reg    <= idx_reg + SW'(1);
            evalid_reg <= 1'b1;
        end
        else
        begin
            evalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        eidx_reg <= idx_reg[IW-1:0];
    end

    // lookup results: first match and lowest free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (cmd.find_begin)
        begin
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else if (find_ev)
        begin
            if (t_valid && (t_key == find_key) && !match_reg)
            begin
                match_reg <= 1'b1;
            end
            if (!t_valid && !free_reg)
            begin
                free_reg <= 1'b1;
            end
        end
    end

    // a new entry starts with a zero window, which the charge unit restarts
    always_ff @(posedge clk)
    begin
        if (cmd.find_begin)
        begin
            cur_start_reg <= '0;
            cur_count_reg <= '0;
        end
        else if (find_ev && t_valid && (t_key == find_key) && !match_reg)
        begin
            match_idx_reg <= eidx_reg;
            cur_start_reg <= t_start;
            cur_count_reg <= t_count;
        end
        if (find_ev && !t_valid && !free_reg)
        begin
            free_idx_reg <= eidx_reg;
        end
    end

    // table writes
    assign slot     = match_reg ? match_idx_reg : free_idx_reg;
    assign ip_we    = cmd.commit_key && is_ip;
    assign ac_we    = cmd.commit_key && !is_ip;
    assign ip_wdata = '{key: ip_key_reg, start: s1_start_reg,
                        count: cnt_out_reg[kfwrl_pkg::IPLIM_W-1:0]};
    assign ac_wdata = '{key: ac_key_reg, start: s1_start_reg,
                        count: cnt_out_reg[kfwrl_pkg::ACLIM_W-1:0]};

    // valid bits and live counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_valid_reg <= '0;
            ac_valid_reg <= '0;
            ip_live_reg  <= '0;
            ac_live_reg  <= '0;
        end
        else
        begin
            if (ip_clr)
            begin
                ip_valid_reg[eidx_reg] <= 1'b0;
                if (ip_live_reg != '0)
                begin
                    ip_live_reg <= ip_live_reg - LW'(1);
                end
            end
            else if (ip_we)
            begin
                ip_valid_reg[slot] <= 1'b1;
                if (!match_reg)
                begin
                    ip_live_reg <= ip_live_reg + LW'(1);
                end
            end

            if (ac_clr)
            begin
                ac_valid_reg[eidx_reg] <= 1'b0;
                if (ac_live_reg != '0)
                begin
                    ac_live_reg <= ac_live_reg - LW'(1);
                end
            end
            else if (ac_we)
            begin
                ac_valid_reg[slot] <= 1'b1;
                if (!match_reg)
                begin
                    ac_live_reg <= ac_live_reg + LW'(1);
                end
            end
            else if (cmd.remove && match_reg)
            begin
                ac_valid_reg[match_idx_reg] <= 1'b0;
                if (ac_live_reg != '0)
                begin
                    ac_live_reg <= ac_live_reg - LW'(1);
                end
            end
        end
    end

    // sweep time and global window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sweep_reg <= '0;
            gstart_reg     <= '0;
            gcount_reg     <= '0;
        end
        else
        begin
            if (cmd.sweep_begin)
            begin
                last_sweep_reg <= now_reg;
            end
            if (cmd.commit_global)
            begin
                gstart_reg <= s1_start_reg;
                gcount_reg <= cnt_out_reg;
            end
        end
    end

    // charge stage 1: restart the window if it is over
    logic [TW-1:0] src_start;
    logic [GW-1:0] src_count;
    logic          src_over;

    assign src_start = cmd.chg_keyed ? cur_start_reg : gstart_reg;
    assign src_count = cmd.chg_keyed ? GW'(cur_count_reg) : gcount_reg;
    assign src_over  = win_over(src_start, now_reg, window_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.chg_s1)
        begin
            s1_start_reg <= src_over ? now_reg : src_start;
            s1_count_reg <= src_over ? '0 : src_count;
        end
    end

    // charge stage 2: limit test and retry time
    logic [GW-1:0] lim;
    logic          deny_c;
    logic [TW-1:0] elapsed;
    logic [WW-1:0] rem;

    assign lim     = !cmd.chg_keyed ? gw_limit_reg :
                     (is_ip ? GW'(ip_limit_reg) : GW'(ac_limit_reg));
    assign deny_c  = (s1_count_reg >= lim);
    assign elapsed = now_reg - s1_start_reg;
    assign rem     = (elapsed >= TW'(window_reg)) ? '0 : window_reg - elapsed[WW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.chg_s2)
        begin
            deny_reg    <= deny_c;
            retry_reg   <= (rem == '0) ? WW'(1) : rem;
            cnt_out_reg <= deny_c ? s1_count_reg : s1_count_reg + GW'(1);
        end
    end

    // status
    logic [CW-1:0] cap;
    logic [TW-1:0] since_sweep;

    assign cap         = (max_keys_reg > CW'(DEPTH)) ? CW'(DEPTH) : max_keys_reg;
    assign since_sweep = now_reg - last_sweep_reg;

    assign sts.sweep_due   = !((last_sweep_reg != '0) && (now_reg >= last_sweep_reg) &&
                               (since_sweep < TW'(window_reg)));
    assign sts.scan_done   = (idx_reg == SW'(DEPTH)) && !evalid_reg;
    assign sts.match_found = match_reg;
    assign sts.free_found  = free_reg;
    assign sts.table_full  = is_ip ? (ip_live_reg >= cap) : (ac_live_reg >= cap);
    assign sts.chg_deny    = deny_reg;

    // result and totals
    logic [kfwrl_pkg::RSN_W-1:0] rsn_i;
    logic [OW-1:0]               pr_cur, pr_inc;
    logic                        is_ok, is_cap;

    assign rsn_i  = cmd.reason - kfwrl_pkg::RSN_W'(1);
    assign pr_cur = (rsn_i < kfwrl_pkg::RSN_W'(kfwrl_pkg::NUM_RSN)) ?
                    per_reason_reg[rsn_i] : '0;
    assign pr_inc = sat_inc(pr_cur);
    assign is_ok  = (cmd.reason == kfwrl_pkg::RSN_NONE);
    assign is_cap = (cmd.reason == kfwrl_pkg::RSN_IP_CAP) ||
                    (cmd.reason == kfwrl_pkg::RSN_AC_CAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allowed_tot_reg <= '0;
            denied_tot_reg  <= '0;
            for (int i = 0; i < kfwrl_pkg::NUM_RSN; i++)
            begin
                per_reason_reg[i] <= '0;
            end
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.result;
            if (cmd.result)
            begin
                if (is_ok)
                begin
                    allowed_tot_reg <= sat_inc(allowed_tot_reg);
                end
                else
                begin
                    denied_tot_reg        <= sat_inc(denied_tot_reg);
                    per_reason_reg[rsn_i] <= pr_inc;
                end
            end
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            allowed                <= is_ok;
            deny_reason            <= cmd.reason;
            retry_after_ms         <= is_ok ? '0 : (is_cap ? window_reg : retry_reg);
            allowed_total          <= is_ok ? sat_inc(allowed_tot_reg) : allowed_tot_reg;
            denied_total           <= is_ok ? denied_tot_reg : sat_inc(denied_tot_reg);
            reason_denied_total    <= is_ok ? '0 : pr_inc;
            ip_entries_in_use      <= ip_live_reg;
            account_entries_in_use <= ac_live_reg;
        end
    end

    // live counts track the valid bits
    a_ip_live: assert property (@(posedge clk) disable iff (!rst_n)
        ip_live_reg == LW'($countones(ip_valid_reg)))
        else $error("ip live count out of step with valid bits");

    a_ac_live: assert property (@(posedge clk) disable iff (!rst_n)
        ac_live_reg == LW'($countones(ac_valid_reg)))
        else $error("account live count out of step with valid bits");

    // an allowed beat carries no reason and no retry time
    a_allow_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && allowed |-> (deny_reason == kfwrl_pkg::RSN_NONE) && (retry_after_ms == '0))
        else $error("allowed result with reason or retry");

    // results never come in adjacent cycles
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in a row");

endmodule

`default_nettype wire

FILE: hdl/keyed_fixed_window_rate_limiter.sv
// Top level of the keyed fixed-window rate limiter.
// Depends on kfwrl_pkg, kfwrl_ctrl, kfwrl_dp (and kfwrl_ram through it).
//
// Usage:
//   Raise start with action, now_ms, ip_key and account_key; the item is taken
//   at a clock edge where start is high and busy is low. action 0 is a login
//   attempt and yields one result beat; action 1 is a success that drops the
//   account entry and yields no result.
//   A result beat sits on the output ports for one cycle with done high; the
//   receiver must take it then, there is no back-pressure.
//   Configuration: cfg_we with cfg_index (0 window, 1 gateway limit, 2 ip
//   limit, 3 account limit, 4 max tracked keys) and cfg_data, only while idle.
// Timing:
//   Each keyed table lookup scans all 256 entries, one RAM read per cycle; a
//   window sweep (at most once per window) scans the table the same way, and
//   a full table adds one sweep check and a rescan. One item at a time.
// Reset:
//   rst_n clears all windows, valid bits, live counts and totals at once and
//   loads the default configuration; no clearing pass is needed.
`default_nettype none

module keyed_fixed_window_rate_limiter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                action,
    input  wire logic [kfwrl_pkg::TIME_W-1:0]        now_ms,
    input  wire logic [kfwrl_pkg::KEY_W-1:0]         ip_key,
    input  wire logic [kfwrl_pkg::KEY_W-1:0]         account_key,
    input  wire logic                                cfg_we,
    input  wire logic [kfwrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [kfwrl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                     done,
    output logic                                     allowed,
    output logic [kfwrl_pkg::RSN_W-1:0]              deny_reason,
    output logic [kfwrl_pkg::WIN_W-1:0]              retry_after_ms,
    output logic [kfwrl_pkg::TOT_W-1:0]              allowed_total,
    output logic [kfwrl_pkg::TOT_W-1:0]              denied_total,
    output logic [kfwrl_pkg::TOT_W-1:0]              reason_denied_total,
    output logic [kfwrl_pkg::LIVE_W-1:0]             ip_entries_in_use,
    output logic [kfwrl_pkg::LIVE_W-1:0]             account_entries_in_use
);

    kfwrl_pkg::cmd_t cmd;
    kfwrl_pkg::sts_t sts;

    kfwrl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    kfwrl_dp u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_we                 (cfg_we),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .now_ms                 (now_ms),
        .ip_key                 (ip_key),
        .account_key            (account_key),
        .cmd                    (cmd),
        .sts                    (sts),
        .done                   (done),
        .allowed                (allowed),
        .deny_reason            (deny_reason),
        .retry_after_ms         (retry_after_ms),
        .allowed_total          (allowed_total),
        .denied_total           (denied_total),
        .reason_denied_total    (reason_denied_total),
        .ip_entries_in_use      (ip_entries_in_use),
        .account_entries_in_use (account_entries_in_use)
    );

endmodule

`default_nettype wire
